// File: hdl/assert_macros.svh
// Assertion macros used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/itoa_pkg.sv
// Shared constants, types and helpers for the integer to ASCII converter.
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 64;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [3:0] DEC_BASE   = 4'd10;

    // Status of the binary-to-BCD unit.
    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

    // One digit to its ASCII code, upper case for hex digits.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < DEC_BASE)
            return CHAR_ZERO + d8;
        else
            return CHAR_A + d8 - {4'b0000, DEC_BASE};
    endfunction

endpackage

// File: hdl/itoa_dabble.sv
// Iterative binary to BCD converter (shift and add-3, one bit per cycle).
module itoa_dabble #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int NDIG       = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   operand,
    output itoa_pkg::dab_status_t   status,
    output logic [NDIG*4-1:0]       bcd
);

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int BW = NDIG * 4;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BW-1:0]         bcd_reg;
    logic [BW-1:0]         bcd_adj;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] > 4'd4)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= operand;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BW-2:0], bin_reg[VALUE_BITS-1]};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// File: hdl/integer_to_ascii_converter.sv
// Integer to ASCII converter: signed/unsigned decimal or upper case hex text, one char per transfer.
// Decimal: the operand is shifted through the shift-and-add-3 unit, the BCD digits are captured,
//   then a minus if negative, then the digit slots, one per cycle while the output slot is free
//   (leading zeros skipped, NDIG slots); the next input is taken once the last char is registered.
// Hex: the nibbles go straight to the digit slots and are emitted the same way. One in flight.
// rst_n is asynchronous, active low; it clears the sequencer and the output valid.
module integer_to_ascii_converter #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic [1:0]  opcode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  character,
    output logic        last
);

    // Decimal digits of 2^VALUE_BITS - 1; also covers the hex digit count.
    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DW   = NDIG * 4;
    localparam int RW   = $clog2(NDIG + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

    state_t          state_reg, state_next;
    logic [DW-1:0]   digits_reg, digits_next;
    logic [RW-1:0]   remain_reg, remain_next;
    logic            started_reg, started_next;
    logic            neg_reg, neg_next;
    logic            minus_reg, minus_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      char_reg, char_next;
    logic            last_reg, last_next;

    logic [VALUE_BITS-1:0] operand;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  is_neg;
    logic                  in_xfer;
    logic                  dab_start;
    logic                  out_free;
    logic [3:0]            top_digit;
    logic [DW-1:0]         bcd;
    itoa_pkg::dab_status_t dab_st;

    // Only the low VALUE_BITS of the operand count. The most negative value
    // negates to itself, which read unsigned is 2^(VALUE_BITS-1).
    assign operand   = value[VALUE_BITS-1:0];
    assign is_neg    = (opcode == itoa_pkg::OP_SDEC) && operand[VALUE_BITS-1];
    assign magnitude = is_neg ? (~operand + VALUE_BITS'(1)) : operand;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign dab_start = in_xfer &&
                       ((opcode == itoa_pkg::OP_SDEC) || (opcode == itoa_pkg::OP_UDEC));

    // Output slot is free when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || out_ready;
    assign top_digit = digits_reg[DW-1 -: 4];

    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dab_start),
        .operand (magnitude),
        .status  (dab_st),
        .bcd     (bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        remain_next    = remain_reg;
        started_next   = started_reg;
        neg_next       = neg_reg;
        minus_next     = minus_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    remain_next  = RW'(NDIG);
                    started_next = 1'b0;
                    neg_next     = is_neg;
                    minus_next   = 1'b0;
                    if (opcode == itoa_pkg::OP_HEX)
                    begin
                        // Nibbles go straight to the digit register.
                        digits_next = {{(DW-VALUE_BITS){1'b0}}, operand};
                        state_next  = ST_EMIT;
                    end
                    else if (opcode != itoa_pkg::OP_NONE)
                    begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (dab_st.done)
                begin
                    digits_next = bcd;
                    minus_next  = neg_reg;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (minus_reg)
                    begin
                        out_valid_next = 1'b1;
                        char_next      = itoa_pkg::CHAR_MINUS;
                        last_next      = 1'b0;
                        minus_next     = 1'b0;
                    end
                    else if (!started_reg && (top_digit == 4'd0) && (remain_reg > RW'(1)))
                    begin
                        // Leading zero: drop it, emit nothing.
                        digits_next = {digits_reg[DW-5:0], 4'b0000};
                        remain_next = remain_reg - RW'(1);
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        char_next      = itoa_pkg::digit_char(top_digit);
                        last_next      = (remain_reg == RW'(1));
                        started_next   = 1'b1;
                        digits_next    = {digits_reg[DW-5:0], 4'b0000};
                        remain_next    = remain_reg - RW'(1);
                        if (remain_reg == RW'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            started_reg   <= started_next;
            neg_reg       <= neg_next;
            minus_reg     <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    `include "assert_macros.svh"

    `ASSERT_SAME(a_ready_unit_idle, in_ready, !dab_st.busy, "accepting while BCD unit busy")
    `ASSERT_SAME(a_done_in_conv, dab_st.done, state_reg == ST_CONV, "BCD done outside conversion")
    `ASSERT_SAME(a_emit_has_digits, state_reg == ST_EMIT, remain_reg != '0, "emit with no digits left")
    `ASSERT_SAME(a_minus_in_emit, minus_reg, state_reg == ST_EMIT, "sign pending outside emit")
    `ASSERT_NEXT(a_start_busy, dab_start, dab_st.busy && state_reg == ST_CONV, "conversion not started")

endmodule

// File: dv/tb.sv
// Testbench for the integer to ASCII converter: self-checking, random idling on both sides.
module tb;

    localparam int TB_VALUE_BITS = itoa_pkg::VALUE_BITS_DEF;
    localparam int RANDOM_NUMBERS = 180;
    // Receiver hold-off long enough to back the block up into its input side.
    localparam int LONG_HOLD_CYCLES = 400;
    // Quiet cycles after the last character.
    localparam int DRAIN_CYCLES = 150;

    // Holds the characters still owed by the block and checks each one that comes out.
    // The text of a number is built here from scratch: sign, then digits most significant first.
    class ascii_text_sb #(int VB = 64);
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } text_char_t;

        text_char_t expected_chars[$];
        int         errors;
        int         chars_seen;

        // Text for one accepted number, queued behind whatever is still owed.
        function void note_number(logic [63:0] v, logic [1:0] op);
            logic [63:0] mask;
            logic [63:0] mag;
            logic [63:0] radix;
            logic [3:0]  dig;
            logic [7:0]  digits[$];
            text_char_t  tc;
            bit          neg;

            // Reserved opcode: the block drops the transfer, nothing comes out.
            if (op == itoa_pkg::OP_NONE)
                return;
            mask  = {64{1'b1}} >> (64 - VB);
            mag   = v & mask;
            radix = (op == itoa_pkg::OP_HEX) ? 64'd16 : 64'd10;
            neg   = (op == itoa_pkg::OP_SDEC) && mag[VB-1];
            // Two's complement magnitude; the most negative value stays 2^(VB-1).
            if (neg)
                mag = (~mag + 64'd1) & mask;
            do
            begin
                dig = 4'(mag % radix);
                digits.push_front((dig < 4'd10)
                                  ? (itoa_pkg::CHAR_ZERO + {4'b0000, dig})
                                  : (itoa_pkg::CHAR_A + {4'b0000, dig} - 8'd10));
                mag = mag / radix;
            end
            while (mag != 64'd0);
            if (neg)
            begin
                tc.ch   = itoa_pkg::CHAR_MINUS;
                tc.last = 1'b0;
                expected_chars.push_back(tc);
            end
            foreach (digits[i])
            begin
                tc.ch   = digits[i];
                tc.last = (i == digits.size() - 1);
                expected_chars.push_back(tc);
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_char(logic [7:0] ch, logic lst);
            text_char_t want;
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("char %h last %b with nothing owed", ch, lst));
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("char %0d: got %h want %h", chars_seen, ch, want.ch));
            if (lst !== want.last)
                report_mismatch($sformatf("char %0d: last got %b want %b",
                                          chars_seen, lst, want.last));
        endtask

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value;
    logic [1:0]  opcode;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  character;
    logic        last;

    ascii_text_sb #(TB_VALUE_BITS) sb;
    int tx_calm;

    integer_to_ascii_converter #(
        .VALUE_BITS(TB_VALUE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Idle length: mostly short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Sender gap before the next number; calm stretches keep valid up back to back.
    function automatic int send_gap();
        int r;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            tx_calm = $urandom_range(10, 40);
            return 0;
        end
        return (r < 50) ? idle_len() : 0;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operand mix: full range, short magnitudes of both signs, decade and binary-power
    // edges (where the digit count changes), and values near the sign bit or near all ones.
    function automatic logic [63:0] rand_operand();
        logic [63:0] p;
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return rand64() >> $urandom_range(1, 63);
            2: return -(rand64() >> $urandom_range(1, 63));
            3:
            begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                return p - 64'd1 + 64'($urandom_range(0, 2));
            end
            4:
            begin
                p = 64'd1 << $urandom_range(0, 63);
                return $urandom_range(0, 1) ? p : p - 64'd1;
            end
            default: return ($urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : {64{1'b1}})
                            ^ 64'($urandom_range(0, 255));
        endcase
    endfunction

    // One number on the input channel. Valid drops only when a gap is due, so a
    // back-to-back number keeps valid high across the edge. Returns at the accepting edge.
    task send_number(logic [63:0] v, logic [1:0] op);
        int gap;
        gap = send_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        opcode   <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_number(v, op);
    endtask

    task wait_all_chars();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: checks every transfer and throttles out_ready on its own schedule.
    // Once, after a few dozen characters, it holds off for a long stretch so the
    // converter fills up and backs up into in_ready while the sender keeps offering.
    initial
    begin
        int  stall_left;
        int  calm_left;
        int  r;
        bit  long_hold_done;
        stall_left     = 0;
        calm_left      = 0;
        long_hold_done = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_char(character, last);
            if (!long_hold_done && sb.chars_seen >= 60)
            begin
                stall_left     = LONG_HOLD_CYCLES;
                long_hold_done = 1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        calm_left = $urandom_range(20, 200);
                    else if (r < 30)
                        stall_left = idle_len();
                end
            end
        end
    end

    // Main sequence: reset, directed numbers, random numbers, drain, verdict.
    initial
    begin
        logic [63:0] dir_val[$];
        logic [1:0]  dir_op[$];
        logic [1:0]  conv_ops[3];
        logic [1:0]  op;
        int          n_conv;
        bit          paused;

        sb       = new();
        tx_calm  = 0;
        conv_ops = '{itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC, itoa_pkg::OP_HEX};
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= 64'd0;
        opcode   <= itoa_pkg::OP_SDEC;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero and single digits, decade edges, the extremes of each reading,
        // every hex letter, the most negative value in all three forms, and the
        // reserved opcode (must produce nothing).
        dir_val = '{64'd0, 64'd0, 64'd0, 64'd9, 64'd10, 64'd15, 64'd16, 64'd255,
                    {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                    64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                    64'h8000_0000_0000_0000,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                    64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF,
                    64'd9999999999999999999, 64'd10000000000000000000,
                    64'hFFFF_FFFF_FFFF_FFF6, 64'h1234_5678_9ABC_DEF0, 64'd1};
        dir_op  = '{itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_HEX, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_SDEC, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_HEX, itoa_pkg::OP_HEX,
                    itoa_pkg::OP_UDEC, itoa_pkg::OP_UDEC,
                    itoa_pkg::OP_SDEC, itoa_pkg::OP_NONE, itoa_pkg::OP_SDEC};
        foreach (dir_val[i])
            send_number(dir_val[i], dir_op[i]);

        // Random: reserved opcode now and then; it does not count toward the total.
        n_conv = 0;
        paused = 0;
        while (n_conv < RANDOM_NUMBERS)
        begin
            op = ($urandom_range(0, 19) == 0) ? itoa_pkg::OP_NONE
                                              : conv_ops[$urandom_range(0, 2)];
            send_number(rand_operand(), op);
            if (op != itoa_pkg::OP_NONE)
                n_conv++;
            // Once, the sender goes quiet until every owed character is out.
            if (!paused && n_conv == RANDOM_NUMBERS / 2)
            begin
                paused = 1;
                in_valid <= 1'b0;
                wait_all_chars();
            end
        end
        in_valid <= 1'b0;

        wait_all_chars();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, sized for the slowest legal run several times over.
    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
